// File: sv/rc4_pkg.sv
// Shared types and constants for the RC4 byte cipher.
// No dependencies; imported by rc4_stream_cipher.
package rc4_pkg;

	localparam int KEY_LEN_W            = 9;
	localparam int KEY_STORE_DEPTH_DEF  = 256;
	localparam logic [KEY_LEN_W-1:0] MIN_KEY_BYTES = 9'd5;
	localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 9'd16;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	// operation codes
	localparam logic [1:0] OP_LOAD     = 2'd0;
	localparam logic [1:0] OP_SCHEDULE = 2'd1;
	localparam logic [1:0] OP_CRYPT    = 2'd2;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] key_position;
		logic [7:0] key_value;
		logic [7:0] data_in;
		logic       end_of_buffer;
	} item_t;

	typedef struct packed {
		logic [7:0] data_out;
		logic       end_of_buffer_out;
	} result_t;

endpackage

// File: sv/rc4_stream_cipher.sv
// RC4 byte cipher top level: permutation store, key store, sequencer, APB register.
// Depends on rc4_pkg.
//
// Usage: a load transaction writes one key byte. A schedule transaction runs the 256-round
// key schedule, each round reading S[k] and the key byte, then S[j], then swapping the two,
// and takes no further transaction until it is done; the permutation is set to the identity
// at once by clearing a row of per-entry valid bits, so there is no separate fill pass. A
// crypt byte passes ST_C_RJ, ST_C_SW and ST_C_FIN before it is registered; the next one is
// taken no earlier than ST_C_FIN, as the single read port of the permutation store serves
// the read of S[i], the dependent read of S[j] and the keystream read in turn, while the two swap
// writes share the write port, the second overlapping the next byte's first read (forwarded
// where both hit the same entry). A finished byte waits in an output register, so the next
// transaction is taken while the result is still unclaimed. Before any schedule the
// permutation reads as zeros and crypt passes data through unchanged. key_length_bytes
// (APB address 0, reset 16) is clamped to 5..KEY_STORE_DEPTH; write it only while idle.
module rc4_stream_cipher
	import rc4_pkg::*;
#(
	parameter int KEY_STORE_DEPTH = KEY_STORE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// item channel
	input  logic                  item_valid,
	output logic                  item_ready,
	input  item_t                 item,
	// result channel
	output logic                  result_valid,
	input  logic                  result_ready,
	output result_t               result,
	// APB configuration port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int KW = $clog2(KEY_STORE_DEPTH);
	localparam logic [KEY_LEN_W-1:0] DEPTH_LEN = KEY_LEN_W'(KEY_STORE_DEPTH);

	// sequencer states
	localparam logic [2:0] ST_IDLE  = 3'd0; // wait for a transaction
	localparam logic [2:0] ST_C_RJ  = 3'd1; // crypt: S[i] back, read S[j]
	localparam logic [2:0] ST_C_SW  = 3'd2; // crypt: write S[i], read keystream entry
	localparam logic [2:0] ST_C_FIN = 3'd3; // crypt: write S[j], deliver result
	localparam logic [2:0] ST_K_RK  = 3'd4; // schedule: read S[k] and key byte
	localparam logic [2:0] ST_K_RJ  = 3'd5; // schedule: update j, read S[j]
	localparam logic [2:0] ST_K_SW  = 3'd6; // schedule: write S[k]
	localparam logic [2:0] ST_K_END = 3'd7; // schedule: last S[j] write, clear indices

	logic [2:0]           state_q;
	logic [7:0]           i_q;        // keystream i, doubles as schedule round counter
	logic [7:0]           j_q;
	logic [7:0]           si_q;       // S[i] (or S[k]) held for the second swap write
	logic [7:0]           din_q;
	logic                 eob_q;
	logic [KW-1:0]        kk_q;       // key byte index, k mod key length
	logic                 keyed_q;    // a schedule has run: unwritten entries read as identity
	logic [255:0]         sbox_valid_q;
	logic [KEY_LEN_W-1:0] key_len_q;
	logic                 result_valid_q;
	result_t              result_q;

	// permutation store and its read-side registers
	logic [7:0]           sbox_mem_q [256];
	logic [7:0]           sbox_rd_q;
	logic                 valid_rd_q;
	logic                 keyed_rd_q;
	logic [7:0]           addr_rd_q;
	logic                 fwd_hit_q;
	logic [7:0]           fwd_data_q;

	// key store
	logic [7:0]           key_mem_q [KEY_STORE_DEPTH];
	logic [7:0]           key_rd_q;

	logic                 accept;
	logic                 out_free;
	logic                 result_load;
	logic                 sched_start;
	logic                 key_we;
	logic                 rd_en;
	logic [7:0]           raddr;
	logic                 we;
	logic [7:0]           waddr;
	logic [7:0]           wdata;
	logic [7:0]           rd_val;
	logic [7:0]           ks;
	logic [KEY_LEN_W-1:0] key_len_eff;
	logic                 cfg_we;

	// Register the APB write on the access phase; addresses 0 to 3 all reach the one register.
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
	assign prdata = (paddr[2] == 1'b0) ? APB_DATA_W'(key_len_q) : '0;

	// Clamp the key length to the supported range.
	always_comb begin
		if (key_len_q < MIN_KEY_BYTES) begin
			key_len_eff = MIN_KEY_BYTES;
		end else if (key_len_q > DEPTH_LEN) begin
			key_len_eff = DEPTH_LEN;
		end else begin
			key_len_eff = key_len_q;
		end
	end

	// Output register parts the two sides: take a new transaction while a result waits,
	// as long as the byte finishing now has somewhere to go.
	assign out_free    = !result_valid_q || result_ready;
	assign item_ready  = (state_q == ST_IDLE) || ((state_q == ST_C_FIN) && out_free);
	assign accept      = item_valid && item_ready;
	assign result_load = (state_q == ST_C_FIN) && out_free;
	assign sched_start = accept && (item.operation == OP_SCHEDULE);
	assign key_we      = accept && (item.operation == OP_LOAD)
		&& ({1'b0, item.key_position} < DEPTH_LEN);

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Value of the last permutation read: a write that hit the same entry in the read cycle
	// wins, then stored data, then the identity (after a schedule) or zero (before one).
	always_comb begin
		if (fwd_hit_q) begin
			rd_val = fwd_data_q;
		end else if (valid_rd_q) begin
			rd_val = sbox_rd_q;
		end else if (keyed_rd_q) begin
			rd_val = addr_rd_q;
		end else begin
			rd_val = '0;
		end
	end

	// Keystream byte: the entry read in ST_C_SW, or S[j] just being written back this cycle.
	// The S[i] write of that cycle is already covered by the forward path.
	assign ks = (addr_rd_q == j_q) ? si_q : rd_val;

	// Read and write port steering of the permutation store.
	always_comb begin
		rd_en = 1'b0;
		raddr = i_q + 8'd1;
		we    = 1'b0;
		waddr = j_q;
		wdata = si_q;
		case (state_q)
			ST_C_RJ: begin
				rd_en = 1'b1;
				raddr = j_q + rd_val;
			end
			ST_C_SW: begin
				rd_en = 1'b1;
				raddr = si_q + rd_val;
				we    = 1'b1;
				waddr = i_q;
				wdata = rd_val;
			end
			ST_C_FIN: begin
				we = 1'b1;
			end
			ST_K_RK: begin
				rd_en = 1'b1;
				raddr = i_q;
				// finish the previous round's swap
				we    = (i_q != 8'd0);
			end
			ST_K_RJ: begin
				rd_en = 1'b1;
				raddr = j_q + rd_val + key_rd_q;
			end
			ST_K_SW: begin
				we    = 1'b1;
				waddr = i_q;
				wdata = rd_val;
			end
			ST_K_END: begin
				we = 1'b1;
			end
			default: begin
				we = 1'b0;
			end
		endcase
		// first read of a crypt transaction, overlapping the last write of the previous one
		if (accept && (item.operation == OP_CRYPT)) begin
			rd_en = 1'b1;
			raddr = i_q + 8'd1;
		end
	end

	// Permutation store: one write and one registered read a cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			sbox_mem_q[waddr] <= wdata;
		end
		if (rd_en) begin
			sbox_rd_q  <= sbox_mem_q[raddr];
			valid_rd_q <= sbox_valid_q[raddr];
			keyed_rd_q <= keyed_q;
			addr_rd_q  <= raddr;
			fwd_hit_q  <= we && (waddr == raddr);
			fwd_data_q <= wdata;
		end
	end

	// Key store: written by load transactions, read once per schedule round.
	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem_q[item.key_position[KW-1:0]] <= item.key_value;
		end
		if (state_q == ST_K_RK) begin
			key_rd_q <= key_mem_q[kk_q];
		end
	end

	// Result payload: no reset needed.
	always_ff @(posedge clk) begin
		if (result_load) begin
			result_q.data_out          <= din_q ^ ks;
			result_q.end_of_buffer_out <= eob_q;
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			i_q            <= '0;
			j_q            <= '0;
			kk_q           <= '0;
			keyed_q        <= 1'b0;
			sbox_valid_q   <= '0;
			key_len_q      <= KEY_LEN_RESET;
			result_valid_q <= 1'b0;
			si_q           <= '0;
			din_q          <= '0;
			eob_q          <= 1'b0;
		end else begin
			if (cfg_we) begin
				key_len_q <= pwdata[KEY_LEN_W-1:0];
			end

			if (result_load) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end

			// Schedule start resets the whole permutation to identity; it wins over any
			// write landing in the same cycle.
			if (sched_start) begin
				sbox_valid_q <= '0;
			end else if (we) begin
				sbox_valid_q[waddr] <= 1'b1;
			end

			case (state_q)
				ST_C_RJ: begin
					si_q    <= rd_val;
					j_q     <= raddr;
					state_q <= ST_C_SW;
				end
				ST_C_SW: begin
					state_q <= ST_C_FIN;
				end
				ST_C_FIN: begin
					// hold here while the output register is still full
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_K_RK: begin
					state_q <= ST_K_RJ;
				end
				ST_K_RJ: begin
					si_q    <= rd_val;
					j_q     <= raddr;
					state_q <= ST_K_SW;
				end
				ST_K_SW: begin
					i_q <= i_q + 8'd1;
					if ((KEY_LEN_W'(kk_q) + 9'd1) == key_len_eff) begin
						kk_q <= '0;
					end else begin
						kk_q <= kk_q + KW'(1);
					end
					state_q <= (i_q == 8'hff) ? ST_K_END : ST_K_RK;
				end
				ST_K_END: begin
					i_q     <= '0;
					j_q     <= '0;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// New transaction: overrides the next state chosen above.
			if (accept) begin
				case (item.operation)
					OP_CRYPT: begin
						i_q     <= i_q + 8'd1;
						din_q   <= item.data_in;
						eob_q   <= item.end_of_buffer;
						state_q <= ST_C_RJ;
					end
					OP_SCHEDULE: begin
						i_q     <= '0;
						j_q     <= '0;
						kk_q    <= '0;
						keyed_q <= 1'b1;
						state_q <= ST_K_RK;
					end
					default: begin
						// load is done by the key store write; unused code is dropped
						state_q <= ST_IDLE;
					end
				endcase
			end
		end
	end

endmodule

// File: test/rc4_stream_cipher_tb.sv
// Self-checking testbench for rc4_stream_cipher: load, schedule and crypt transactions with
// random idling on both channels, every output byte checked against a behavioural cipher.
// Depends on rc4_pkg and rc4_stream_cipher.
module rc4_stream_cipher_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rc4_pkg::*;

	// operation code the block must swallow without a result
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic [APB_ADDR_W-1:0] KEY_LEN_ADDR = '0;
	// long enough for a key schedule to run out
	localparam int SETTLE_CYCLES = 800;
	localparam int LONG_HOLD = 400;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int PHASE_ITEMS = 100;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	item_t item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	result_t result;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;

	// Behavioural cipher state, kept in step with the block at each accepted transaction.
	bit [7:0] perm_tbl [256];
	bit [7:0] key_tbl [256];
	bit key_known [256];
	bit [7:0] idx_i;
	bit [7:0] idx_j;
	bit [KEY_LEN_W-1:0] key_len_cfg = KEY_LEN_RESET;
	result_t pending_bytes [$];

	int mismatches;
	int sent_items;
	int cycle_count;
	bit no_idle;
	bit hold_off_req;

	rc4_stream_cipher u_top (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Abort a hung run; the limit is far above the slowest legitimate run.
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	// Mostly no gap, sometimes a short one, now and then a long one.
	function automatic int draw_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Result sink: random stalls, plus one long hold-off on request so that the
	// output register fills and the block has to stall its input channel.
	initial begin : result_sink
		int stall;
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				result_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				stall = draw_gap();
				if (stall > 0) begin
					result_ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
				result_ready <= 1'b1;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	end

	// Compare each accepted output byte with the oldest predicted one.
	initial begin : byte_checker
		result_t want;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && result_ready) begin
				if (pending_bytes.size() == 0) begin
					mismatches++;
					$display("%0t: output with nothing expected: expected none, actual %02h/%0b",
						$time, result.data_out, result.end_of_buffer_out);
				end else begin
					want = pending_bytes.pop_front();
					if (result.data_out !== want.data_out) begin
						mismatches++;
						$display("%0t: data_out mismatch: expected %02h, actual %02h",
							$time, want.data_out, result.data_out);
					end
					if (result.end_of_buffer_out !== want.end_of_buffer_out) begin
						mismatches++;
						$display("%0t: end_of_buffer_out mismatch: expected %0b, actual %0b",
							$time, want.end_of_buffer_out, result.end_of_buffer_out);
					end
				end
			end
		end
	end

	// Number of key bytes the schedule cycles through, after clamping.
	function automatic int key_span();
		int n;
		n = key_len_cfg;
		if (n < MIN_KEY_BYTES)
			n = MIN_KEY_BYTES;
		if (n > KEY_STORE_DEPTH_DEF)
			n = KEY_STORE_DEPTH_DEF;
		return n;
	endfunction

	// A schedule is only legal once every key byte it will read has been loaded.
	function automatic bit schedule_safe();
		for (int p = 0; p < key_span(); p++)
			if (!key_known[p])
				return 1'b0;
		return 1'b1;
	endfunction

	// Advance the behavioural cipher by one accepted transaction.
	task automatic rc4_predict(input item_t it);
		int n;
		bit [7:0] j;
		bit [7:0] t;
		result_t r;
		case (it.operation)
			OP_LOAD: begin
				key_tbl[it.key_position] = it.key_value;
				key_known[it.key_position] = 1'b1;
			end
			OP_SCHEDULE: begin
				n = key_span();
				for (int k = 0; k < 256; k++)
					perm_tbl[k] = 8'(k);
				j = 8'd0;
				for (int k = 0; k < 256; k++) begin
					j = j + perm_tbl[k] + key_tbl[k % n];
					t = perm_tbl[k];
					perm_tbl[k] = perm_tbl[j];
					perm_tbl[j] = t;
				end
				idx_i = 8'd0;
				idx_j = 8'd0;
			end
			OP_CRYPT: begin
				idx_i = idx_i + 8'd1;
				idx_j = idx_j + perm_tbl[idx_i];
				t = perm_tbl[idx_i];
				perm_tbl[idx_i] = perm_tbl[idx_j];
				perm_tbl[idx_j] = t;
				t = perm_tbl[idx_i] + perm_tbl[idx_j];
				r.data_out = it.data_in ^ perm_tbl[t];
				r.end_of_buffer_out = it.end_of_buffer;
				pending_bytes.push_back(r);
			end
			default: ; // unused code: no effect, no result
		endcase
	endtask

	// Every field random; callers override what matters for the operation.
	function automatic item_t random_item(input logic [1:0] op);
		item_t it;
		it.operation = op;
		it.key_position = 8'($urandom_range(255));
		it.key_value = 8'($urandom_range(255));
		it.data_in = 8'($urandom_range(255));
		it.end_of_buffer = 1'($urandom_range(1));
		return it;
	endfunction

	// Offer one transaction, hold it until accepted, then predict and maybe idle.
	// With no gap, valid stays high and the next call just replaces the payload.
	task automatic send_item(input item_t it);
		int gap;
		item <= it;
		item_valid <= 1'b1;
		do
			@(posedge clk);
		while (!item_ready);
		rc4_predict(it);
		if (it.operation != OP_UNUSED)
			sent_items++;
		gap = draw_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic load_key(input int pos, input logic [7:0] value);
		item_t it;
		it = random_item(OP_LOAD);
		it.key_position = 8'(pos);
		it.key_value = value;
		send_item(it);
	endtask

	// One buffer of crypt transactions, the last marked end-of-buffer.
	task automatic send_message(input int len);
		item_t it;
		for (int k = 0; k < len; k++) begin
			it = random_item(OP_CRYPT);
			it.end_of_buffer = (k == len - 1);
			send_item(it);
		end
	endtask

	// Drop valid, wait for every predicted byte, then let a schedule run out.
	task automatic settle_idle();
		item_valid <= 1'b0;
		while (pending_bytes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write key_length_bytes while idle and read it back.
	task automatic set_key_length(input logic [KEY_LEN_W-1:0] len);
		settle_idle();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= KEY_LEN_ADDR;
		pwdata <= APB_DATA_W'(len);
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		key_len_cfg = len;
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (prdata[KEY_LEN_W-1:0] !== len) begin
			mismatches++;
			$display("%0t: key_length_bytes readback: expected %0d, actual %0d",
				$time, len, prdata[KEY_LEN_W-1:0]);
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Fill any key bytes still unwritten, refresh a few, then schedule.
	task automatic rekey();
		int n;
		n = key_span();
		for (int p = 0; p < n; p++)
			if (!key_known[p])
				load_key(p, 8'($urandom_range(255)));
		repeat ($urandom_range(1, 6))
			load_key($urandom_range(n - 1), 8'($urandom_range(255)));
		send_item(random_item(OP_SCHEDULE));
	endtask

	// Mostly rekeys and whole buffers; else stray loads, lone bytes, junk codes, bare schedules.
	task automatic run_traffic(input int budget);
		int start;
		int pick;
		start = sent_items;
		while (sent_items - start < budget) begin
			pick = $urandom_range(99);
			if (pick < 12)
				rekey();
			else if (pick < 72)
				send_message($urandom_range(1, 24));
			else if (pick < 88)
				repeat ($urandom_range(1, 3)) send_item(random_item(OP_LOAD));
			else if (pick < 93)
				send_item(random_item(OP_UNUSED));
			else if (pick < 97)
				send_item(random_item(OP_CRYPT));
			else if (schedule_safe())
				send_item(random_item(OP_SCHEDULE));
		end
	endtask

	// Before any schedule the permutation is all zeros: bytes pass through unchanged.
	// Also push an unused code and loads at both ends of the key store.
	task automatic test_unkeyed_passthrough();
		item_t it;
		it = random_item(OP_CRYPT);
		it.data_in = 8'h00;
		it.end_of_buffer = 1'b0;
		send_item(it);
		it.data_in = 8'hff;
		it.end_of_buffer = 1'b1;
		send_item(it);
		send_item(random_item(OP_UNUSED));
		load_key(0, 8'h00);
		load_key(255, 8'hff);
		it.data_in = 8'h5a;
		it.end_of_buffer = 1'b0;
		send_item(it);
		it.data_in = 8'ha5;
		it.end_of_buffer = 1'b1;
		send_item(it);
	endtask

	// Shortest legal key with extreme byte values, then a buffer opening with extreme data.
	task automatic test_min_key_schedule();
		item_t it;
		set_key_length(MIN_KEY_BYTES);
		load_key(0, 8'hff);
		load_key(1, 8'h00);
		load_key(2, 8'h80);
		load_key(3, 8'h01);
		load_key(4, 8'h7f);
		send_item(random_item(OP_SCHEDULE));
		for (int k = 0; k < 8; k++) begin
			it = random_item(OP_CRYPT);
			if (k == 0)
				it.data_in = 8'h00;
			else if (k == 1)
				it.data_in = 8'hff;
			it.end_of_buffer = (k == 7);
			send_item(it);
		end
	endtask

	// Key lengths below, at and above the legal range, each with fresh traffic.
	task automatic test_key_length_sweep();
		int sweep [8];
		sweep = '{0, 4, 40, 255, 256, 257, 511, 0};
		sweep[7] = $urandom_range(MIN_KEY_BYTES, KEY_STORE_DEPTH_DEF);
		foreach (sweep[s]) begin
			set_key_length(KEY_LEN_W'(sweep[s]));
			rekey();
			run_traffic(PHASE_ITEMS);
		end
	endtask

	// Hold the sink off for a long stretch while crypt bytes keep coming.
	task automatic test_output_backpressure();
		hold_off_req = 1'b1;
		no_idle = 1'b1;
		send_message(48);
		no_idle = 1'b0;
	endtask

	// Back-to-back on both channels: no gaps, no stalls.
	task automatic test_no_idle_burst();
		no_idle = 1'b1;
		run_traffic(PHASE_ITEMS);
		no_idle = 1'b0;
	endtask

	initial begin : run_tests
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_unkeyed_passthrough();
		// first random phase runs on the reset key length
		run_traffic(PHASE_ITEMS);
		test_min_key_schedule();
		test_key_length_sweep();
		test_output_backpressure();
		test_no_idle_burst();
		settle_idle();
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
